FILE: rtl/tef_pkg.sv
// Types, constants and register codes shared by the trapezoidal energy filter.
// No dependencies; every other file of the block imports this package.
package tef_pkg;

    localparam int DELAY_DEPTH_DEF = 1024;
    localparam int MAX_RISE_DEF    = 256;
    localparam int MAX_GAP_DEF     = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SAMPLE_W   = 16;
    localparam int LEN_W      = 9;
    localparam int BASE_W     = 20;
    localparam int COEF_W     = 32;
    localparam int NORM_W     = 17;
    localparam int VALUE_W    = 40;
    localparam int COUNT_W    = 11;
    localparam int SUM_W      = 26;
    localparam int SCALED_W   = SUM_W + 4;
    localparam int BPROD_W    = BASE_W + LEN_W;
    localparam int PROD_W     = COEF_W + SUM_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 24;
    localparam int HI_W       = ACC_W - FRAC_SHIFT;
    localparam int PH_W       = HI_W + NORM_W;
    localparam int PL_W       = NORM_W;
    localparam int MERGE_W    = PH_W + 1;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [MERGE_W-1:0] NEG_LIMIT = MERGE_W'(1) << (VALUE_W - 1);
    localparam logic [MERGE_W-1:0] POS_LIMIT = NEG_LIMIT - MERGE_W'(1);
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam logic [LEN_W-1:0]         RISE_RST = LEN_W'(8);
    localparam logic [LEN_W-1:0]         GAP_RST  = LEN_W'(12);
    localparam logic [BASE_W-1:0]        BASE_RST = '0;
    localparam logic signed [COEF_W-1:0] COEF_T_RST = -COEF_W'(65536);
    localparam logic signed [COEF_W-1:0] COEF_L_RST = COEF_W'(131072);
    localparam logic [NORM_W-1:0]        NORM_RST = NORM_W'(2731);

    typedef enum logic [2:0] {
        REG_RISE,
        REG_GAP,
        REG_BASE,
        REG_COEF_T,
        REG_COEF_L,
        REG_NORM
    } t_reg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                trace_start;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] filter_value;
        logic                      window_full;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0]         rise_length;
        logic [LEN_W-1:0]         gap_length;
        logic [BASE_W-1:0]        baseline_level;
        logic signed [COEF_W-1:0] coef_trailing;
        logic signed [COEF_W-1:0] coef_leading;
        logic [NORM_W-1:0]        norm_recip;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ0,
        S_READ1,
        S_SUMS,
        S_MULT,
        S_ACCUM,
        S_MAG,
        S_SCALE,
        S_MERGE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic read0;
        logic read1;
        logic sums;
        logic mult;
        logic accum;
        logic mag;
        logic scale;
        logic merge;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic out_stall;
    } t_status;

endpackage

FILE: rtl/trapezoidal_energy_filter.sv
// Trapezoidal energy filter with pole-zero corrected window weights.
// Input request: i_in_data carries one ADC sample and a trace-start flag,
// accepted when i_in_valid and o_in_ready are both high. Output request:
// o_out_data carries filter_value (signed, 8 fraction bits) and window_full,
// taken when o_out_valid and i_out_ready are both high. Every input gives one
// output. The block works on one sample at a time: a sample that fills the
// windows goes through two reads, sums, products, accumulation, magnitude,
// scaling and merge before the output register is loaded; one that does
// not goes from the first read to the load. A new sample is taken only in
// the idle state, after the last one is loaded. The sequence is set by the
// two-port running-total memory, which needs two read steps for the three
// window edges. A waiting output does not block acceptance of the
// next sample; the block holds in its last step only when a new result is
// ready and the earlier one has not been taken. Synchronous reset clears the
// sample counter, the running total, the write pointer, the output valid and
// the configuration registers; the running-total memory needs no clearing.
// Configuration uses the APB port; write it only while the block is idle.
module trapezoidal_energy_filter #(
    parameter int DELAY_DEPTH = tef_pkg::DELAY_DEPTH_DEF,
    parameter int MAX_RISE    = tef_pkg::MAX_RISE_DEF,
    parameter int MAX_GAP     = tef_pkg::MAX_GAP_DEF,
    parameter int SAMPLE_BITS = tef_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tef_pkg::PADDR_W-1:0]  paddr,
    input  logic [tef_pkg::PDATA_W-1:0]  pwdata,
    output logic [tef_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  tef_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tef_pkg::t_out_item           o_out_data
);
    import tef_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    assign pready = 1'b1;

    tef_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    tef_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tef_datapath #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .MAX_RISE    (MAX_RISE),
        .MAX_GAP     (MAX_GAP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_data)
    );

endmodule

FILE: rtl/tef_regs.sv
// Configuration register file with APB-style access.
// Depends on tef_pkg for the register codes, reset values and t_cfg.
module tef_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tef_pkg::PADDR_W-1:0]  paddr,
    input  logic [tef_pkg::PDATA_W-1:0]  pwdata,
    output logic [tef_pkg::PDATA_W-1:0]  prdata,
    output tef_pkg::t_cfg                o_cfg
);
    import tef_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx   = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rise_length    <= RISE_RST;
            r_cfg.gap_length     <= GAP_RST;
            r_cfg.baseline_level <= BASE_RST;
            r_cfg.coef_trailing  <= COEF_T_RST;
            r_cfg.coef_leading   <= COEF_L_RST;
            r_cfg.norm_recip     <= NORM_RST;
        end else if (wr_en) begin
            case (idx)
                REG_RISE:   r_cfg.rise_length    <= pwdata[LEN_W-1:0];
                REG_GAP:    r_cfg.gap_length     <= pwdata[LEN_W-1:0];
                REG_BASE:   r_cfg.baseline_level <= pwdata[BASE_W-1:0];
                REG_COEF_T: r_cfg.coef_trailing  <= pwdata[COEF_W-1:0];
                REG_COEF_L: r_cfg.coef_leading   <= pwdata[COEF_W-1:0];
                REG_NORM:   r_cfg.norm_recip     <= pwdata[NORM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_RISE:   prdata = PDATA_W'(r_cfg.rise_length);
            REG_GAP:    prdata = PDATA_W'(r_cfg.gap_length);
            REG_BASE:   prdata = PDATA_W'(r_cfg.baseline_level);
            REG_COEF_T: prdata = PDATA_W'(r_cfg.coef_trailing);
            REG_COEF_L: prdata = PDATA_W'(r_cfg.coef_leading);
            REG_NORM:   prdata = PDATA_W'(r_cfg.norm_recip);
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: rtl/tef_ctrl.sv
// Sequencer for one request: accept, window reads, sums, products, scaling, output.
// Depends on tef_pkg for t_state, t_cmd and t_status.
module tef_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tef_pkg::t_status   i_status,
    output tef_pkg::t_cmd      o_cmd
);
    import tef_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_READ0;
            S_READ0: n_state = i_status.full ? S_READ1 : S_DONE;
            S_READ1: n_state = S_SUMS;
            S_SUMS:  n_state = S_MULT;
            S_MULT:  n_state = S_ACCUM;
            S_ACCUM: n_state = S_MAG;
            S_MAG:   n_state = S_SCALE;
            S_SCALE: n_state = S_MERGE;
            S_MERGE: n_state = S_DONE;
            S_DONE:  if (!i_status.out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_READ0: o_cmd.read0 = 1'b1;
            S_READ1: o_cmd.read1 = 1'b1;
            S_SUMS:  o_cmd.sums  = 1'b1;
            S_MULT:  o_cmd.mult  = 1'b1;
            S_ACCUM: o_cmd.accum = 1'b1;
            S_MAG:   o_cmd.mag   = 1'b1;
            S_SCALE: o_cmd.scale = 1'b1;
            S_MERGE: o_cmd.merge = 1'b1;
            S_DONE:  o_cmd.load  = !i_status.out_stall;
            default: ;
        endcase
    end

endmodule

FILE: rtl/tef_datapath.sv
// Datapath: running-total store, window sums, coefficient products, scaling, output register.
// Depends on tef_pkg; driven by tef_ctrl through t_cmd and answers with t_status.
module tef_datapath #(
    parameter int DELAY_DEPTH = tef_pkg::DELAY_DEPTH_DEF,
    parameter int MAX_RISE    = tef_pkg::MAX_RISE_DEF,
    parameter int MAX_GAP     = tef_pkg::MAX_GAP_DEF,
    parameter int SAMPLE_BITS = tef_pkg::SAMPLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tef_pkg::t_cfg       i_cfg,
    input  tef_pkg::t_cmd       i_cmd,
    output tef_pkg::t_status    o_status,
    input  tef_pkg::t_in_item   i_in_item,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output tef_pkg::t_out_item  o_out_item
);
    import tef_pkg::*;

    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int PW   = SAMPLE_BITS + LEN_W;
    localparam int MW   = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
    localparam int LO_W = FRAC_SHIFT + NORM_W;

    logic [PW-1:0] mem [DELAY_DEPTH];

    logic [AW-1:0]      r_wp;
    logic [AW-1:0]      r_newest;
    logic [PW-1:0]      r_total;
    logic [COUNT_W-1:0] r_cnt;
    logic               r_full;
    logic [PW-1:0]      r_rd_a;
    logic [PW-1:0]      r_rd_b;
    logic [PW-1:0]      r_edge_l;
    logic [PW-1:0]      r_edge_g;
    logic [BPROD_W-1:0] r_bp_rise;
    logic [BPROD_W-1:0] r_bp_gap;

    logic signed [SUM_W-1:0]  r_sum_t;
    logic signed [SUM_W-1:0]  r_sum_g;
    logic signed [SUM_W-1:0]  r_sum_l;
    logic signed [PROD_W-1:0] r_mul_t;
    logic signed [PROD_W-1:0] r_mul_l;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_neg;
    logic [ACC_W-1:0]         r_mag;
    logic [PH_W-1:0]          r_ph;
    logic [PL_W-1:0]          r_pl;
    logic [MERGE_W-1:0]       r_prod;
    logic                     r_out_valid;
    t_out_item                r_out_item;

    logic [LEN_W-1:0]          rise_c;
    logic [LEN_W-1:0]          gap_c;
    logic [COUNT_W-1:0]        need;
    logic [COUNT_W-1:0]        age_l;
    logic [COUNT_W-1:0]        age_g;
    logic [COUNT_W-1:0]        age_t;
    logic [COUNT_W-1:0]        cnt_next;
    logic [AW-1:0]             rd_addr_a;
    logic [AW-1:0]             rd_addr_b;
    logic [PW-1:0]             smp;
    logic [LO_W-1:0]           lo_full;
    logic signed [VALUE_W-1:0] sat_value;

    function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] n,
                                                input logic [COUNT_W-1:0] age);
        logic [MW-1:0] nn;
        logic [MW-1:0] aa;
        nn = MW'(n);
        aa = MW'(age);
        if (nn >= aa) begin
            return AW'(nn - aa);
        end
        return AW'(nn + MW'(DELAY_DEPTH) - aa);
    endfunction

    function automatic logic signed [SUM_W-1:0] correct(input logic [PW-1:0] raw,
                                                        input logic [BPROD_W-1:0] bp);
        logic signed [SCALED_W-1:0] t;
        t = SCALED_W'({raw, 4'b0000}) - SCALED_W'(bp);
        if (t[SCALED_W-1]) begin
            t = t + SCALED_W'(15);
        end
        return SUM_W'(t >>> 4);
    endfunction

    always_comb begin
        if (i_cfg.rise_length == '0) begin
            rise_c = LEN_W'(1);
        end else if (int'(i_cfg.rise_length) > MAX_RISE) begin
            rise_c = LEN_W'(MAX_RISE);
        end else begin
            rise_c = i_cfg.rise_length;
        end
        if (i_cfg.gap_length == '0) begin
            gap_c = LEN_W'(1);
        end else if (int'(i_cfg.gap_length) > MAX_GAP) begin
            gap_c = LEN_W'(MAX_GAP);
        end else begin
            gap_c = i_cfg.gap_length;
        end
    end

    assign need  = (COUNT_W'(rise_c) << 1) + COUNT_W'(gap_c);
    assign age_l = COUNT_W'(rise_c) - COUNT_W'(1);
    assign age_g = COUNT_W'(rise_c) + COUNT_W'(gap_c) - COUNT_W'(1);
    assign age_t = need - COUNT_W'(1);

    assign smp = PW'(i_in_item.sample[SAMPLE_BITS-1:0]);

    always_comb begin
        if (i_in_item.trace_start) begin
            cnt_next = COUNT_W'(1);
        end else if (r_cnt != COUNT_MAX) begin
            cnt_next = r_cnt + COUNT_W'(1);
        end else begin
            cnt_next = r_cnt;
        end
    end

    assign rd_addr_a = i_cmd.read1 ? back_addr(r_newest, age_t) : back_addr(r_newest, age_l);
    assign rd_addr_b = back_addr(r_newest, age_g);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            mem[r_wp] <= r_total;
        end
        if (i_cmd.read0 || i_cmd.read1) begin
            r_rd_a <= mem[rd_addr_a];
        end
        if (i_cmd.read0) begin
            r_rd_b <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_total <= '0;
            r_cnt   <= '0;
            r_full  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_wp    <= (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            r_total <= r_total + smp;
            r_cnt   <= cnt_next;
            r_full  <= (cnt_next >= need);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_newest <= r_wp;
        end
        if (i_cmd.read0) begin
            r_bp_rise <= BPROD_W'(i_cfg.baseline_level) * BPROD_W'(rise_c);
            r_bp_gap  <= BPROD_W'(i_cfg.baseline_level) * BPROD_W'(gap_c);
        end
        if (i_cmd.read1) begin
            r_edge_l <= r_rd_a;
            r_edge_g <= r_rd_b;
        end
        if (i_cmd.sums) begin
            r_sum_l <= correct(r_total - r_edge_l, r_bp_rise);
            r_sum_g <= correct(r_edge_l - r_edge_g, r_bp_gap);
            r_sum_t <= correct(r_edge_g - r_rd_a, r_bp_rise);
        end
        if (i_cmd.mult) begin
            r_mul_t <= PROD_W'(i_cfg.coef_trailing) * PROD_W'(r_sum_t);
            r_mul_l <= PROD_W'(i_cfg.coef_leading) * PROD_W'(r_sum_l);
        end
        if (i_cmd.accum) begin
            r_acc <= ACC_W'(r_mul_t) + ACC_W'(r_mul_l) + (ACC_W'(r_sum_g) <<< 16);
        end
        if (i_cmd.mag) begin
            r_neg <= r_acc[ACC_W-1];
            r_mag <= r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        end
        if (i_cmd.scale) begin
            r_ph <= PH_W'(r_mag[ACC_W-1:FRAC_SHIFT]) * PH_W'(i_cfg.norm_recip);
            r_pl <= lo_full[FRAC_SHIFT+NORM_W-1:FRAC_SHIFT];
        end
        if (i_cmd.merge) begin
            r_prod <= MERGE_W'(r_ph) + MERGE_W'(r_pl);
        end
    end

    assign lo_full = LO_W'(r_mag[FRAC_SHIFT-1:0]) * LO_W'(i_cfg.norm_recip);

    always_comb begin
        if (r_neg) begin
            sat_value = (r_prod > NEG_LIMIT) ? VALUE_MIN : VALUE_W'(-r_prod);
        end else begin
            sat_value = (r_prod > POS_LIMIT) ? VALUE_MAX : VALUE_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_item.filter_value <= r_full ? sat_value : '0;
            r_out_item.window_full  <= r_full;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out_item;
    assign o_status.full      = r_full;
    assign o_status.out_stall = r_out_valid && !i_out_ready;

endmodule

FILE: rtl/tef_checker.sv
// Port-level checks for the trapezoidal energy filter, bound to the top level.
// Depends on tef_pkg for the request types.
module tef_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input tef_pkg::t_out_item           o_out_data
);
    import tef_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output request dropped or changed while stalled");

    a_zero_when_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.window_full |-> o_out_data.filter_value == '0)
        else $error("non-zero value before the windows are full");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one is in progress");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid not cleared by reset");

endmodule

bind trapezoidal_energy_filter tef_checker u_tef_checker (.*);

FILE: tb/tb_top.sv
// Self-checking bench for the trapezoidal energy filter: random traces through valid/ready
// requests, APB setup of the windows and weights, expected energies computed alongside.
// Depends on tef_pkg and trapezoidal_energy_filter.
`timescale 1ns / 100ps

module tb_top;
    import tef_pkg::*;

    localparam int DEPTH = DELAY_DEPTH_DEF;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_data;

    t_in_item            sample_queue[$];
    t_out_item           expected_energies[$];
    t_out_item           want_res;
    bit                  req_taken;
    bit                  no_idle;
    int                  mismatch_count;
    int                  queued_items;

    logic [LEN_W-1:0]         cfg_rise = RISE_RST;
    logic [LEN_W-1:0]         cfg_gap = GAP_RST;
    logic [BASE_W-1:0]        cfg_base = BASE_RST;
    logic signed [COEF_W-1:0] cfg_coef_t = COEF_T_RST;
    logic signed [COEF_W-1:0] cfg_coef_l = COEF_L_RST;
    logic [NORM_W-1:0]        cfg_norm = NORM_RST;

    logic [SAMPLE_W-1:0] sample_hist[DEPTH];
    int                  wr_ptr;
    int                  trace_count;

    trapezoidal_energy_filter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int clamp_len(logic [LEN_W-1:0] v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic longint corrected_sum(int newest, int age, int count);
        longint raw;
        int     pos;
        raw = 0;
        for (int k = 0; k < count; k++) begin
            pos = (newest + DEPTH - ((age + k) % DEPTH)) % DEPTH;
            raw += sample_hist[pos];
        end
        raw = raw * 16 - longint'(cfg_base) * count;
        return raw / 16;
    endfunction

    function automatic t_out_item predict_energy(t_in_item req);
        int          rise, gap, newest;
        longint      lead, gap_s, trail, acc, v;
        logic [63:0] mag, prod;
        bit          neg;
        t_out_item   res;
        rise = clamp_len(cfg_rise, MAX_RISE_DEF);
        gap = clamp_len(cfg_gap, MAX_GAP_DEF);
        newest = wr_ptr;
        sample_hist[newest] = req.sample;
        wr_ptr = (newest + 1) % DEPTH;
        if (req.trace_start) trace_count = 0;
        if (trace_count < int'(COUNT_MAX)) trace_count++;
        res = '0;
        if (trace_count >= 2 * rise + gap) begin
            lead = corrected_sum(newest, 0, rise);
            gap_s = corrected_sum(newest, rise, gap);
            trail = corrected_sum(newest, rise + gap, rise);
            acc = longint'(cfg_coef_t) * trail + gap_s * 65536 + longint'(cfg_coef_l) * lead;
            neg = acc < 0;
            mag = neg ? 64'(-acc) : 64'(acc);
            prod = (mag >> 24) * cfg_norm + (((mag & 64'hFF_FFFF) * cfg_norm) >> 24);
            if (neg) begin
                v = (prod > 64'd549755813888) ? longint'(VALUE_MIN) : -longint'(prod);
            end else begin
                v = (prod > 64'd549755813887) ? longint'(VALUE_MAX) : longint'(prod);
            end
            res.filter_value = v[VALUE_W-1:0];
            res.window_full = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(int mode, int level);
        int v;
        case (mode)
            0: v = int'($urandom_range(0, 65535));
            1: v = level + int'($urandom_range(0, 400)) - 200;
            2: v = $urandom_range(0, 1) ? 65535 : 0;
            default: v = ($urandom_range(0, 3) == 0) ? level + int'($urandom_range(0, 20000)) : level;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [31:0] pick_len();
        logic [31:0] len;
        len = ($urandom_range(0, 15) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
        if ($urandom_range(0, 3) == 0) len |= $urandom() & 32'hFFFF_FE00;
        return len;
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return 32'(int'($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    task automatic push_item(int smp, bit start);
        t_in_item req;
        req.sample = smp[SAMPLE_W-1:0];
        req.trace_start = start;
        sample_queue.insert(sample_queue.size(), req);
        queued_items++;
    endtask

    task automatic queue_trace(int len, int mode, int level, bit noisy);
        t_in_item req;
        for (int n = 0; n < len; n++) begin
            req.sample = pick_sample(mode, level);
            req.trace_start = (n == 0);
            if (noisy && $urandom_range(0, 29) == 0) req.trace_start = ~req.trace_start;
            sample_queue.insert(sample_queue.size(), req);
            queued_items++;
        end
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = PADDR_W'(int'(idx) * 4);
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_RISE:   cfg_rise = value[LEN_W-1:0];
            REG_GAP:    cfg_gap = value[LEN_W-1:0];
            REG_BASE:   cfg_base = value[BASE_W-1:0];
            REG_COEF_T: cfg_coef_t = value;
            REG_COEF_L: cfg_coef_l = value;
            REG_NORM:   cfg_norm = value[NORM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [31:0] rise, logic [31:0] gap, logic [31:0] base,
                                 logic [31:0] coef_t, logic [31:0] coef_l, logic [31:0] norm);
        write_reg(REG_RISE, rise);
        write_reg(REG_GAP, gap);
        write_reg(REG_BASE, base);
        write_reg(REG_COEF_T, coef_t);
        write_reg(REG_COEF_L, coef_l);
        write_reg(REG_NORM, norm);
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sample_queue.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_energies.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic int window_need();
        return 2 * clamp_len(cfg_rise, MAX_RISE_DEF) + clamp_len(cfg_gap, MAX_GAP_DEF);
    endfunction

    // driver: hold a request until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (!i_in_valid || req_taken) begin
                if (sample_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 32)) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= sample_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= 32);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        req_taken = i_rst_n && i_in_valid && o_in_ready;
        if (req_taken) begin
            expected_energies.insert(expected_energies.size(), predict_energy(i_in_data));
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_energies.size() == 0) begin
                $error("unexpected result: filter_value %0d window_full %0b",
                       $signed(o_out_data.filter_value), o_out_data.window_full);
                mismatch_count++;
            end else begin
                want_res = expected_energies.pop_front();
                if (o_out_data.filter_value !== want_res.filter_value) begin
                    $error("filter_value: expected %0d, got %0d",
                           $signed(want_res.filter_value), $signed(o_out_data.filter_value));
                    mismatch_count++;
                end
                if (o_out_data.window_full !== want_res.window_full) begin
                    $error("window_full: expected %0b, got %0b",
                           want_res.window_full, o_out_data.window_full);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int          len;
        logic [31:0] word;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // lengths clamp up from zero, saturating weights
        load_settings(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_FFFF);
        push_item(5, 1'b0);
        push_item(0, 1'b1);
        push_item(0, 1'b0);
        push_item(65535, 1'b0);
        push_item(0, 1'b0);
        push_item(0, 1'b0);
        push_item(65535, 1'b1);
        push_item(65535, 1'b0);
        push_item(65535, 1'b0);
        push_item(1, 1'b1);
        push_item(65534, 1'b0);
        push_item(32768, 1'b0);
        drain();

        // full baseline against empty samples
        load_settings(32'd2, 32'd3, 32'h000F_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd65536);
        push_item(0, 1'b1);
        repeat (6) push_item(0, 1'b0);
        push_item(65535, 1'b0);
        push_item(65535, 1'b0);
        push_item(43690, 1'b0);
        push_item(21845, 1'b0);
        push_item(1, 1'b0);
        drain();

        load_settings(32'd8, 32'd12, 32'd0, 32'hFFFF_0000, 32'd131072, 32'd2731);
        repeat (2) queue_trace(window_need() + $urandom_range(0, 30), 3, 1000, 1'b0);
        drain();

        // longest windows one at a time: rise clamps down, gap clamps up, and the reverse
        load_settings(32'h1FF, 32'd0, $urandom_range(0, 1048575), pick_coef(), pick_coef(),
                      32'd2731);
        queue_trace(window_need() + 20, 0, 0, 1'b0);
        drain();
        load_settings(32'd0, 32'hFFFF_FFFF, $urandom_range(0, 1048575), pick_coef(),
                      pick_coef(), 32'd128);
        queue_trace(window_need() + 30, 1, int'(cfg_base >> 4), 1'b0);
        drain();

        // long trace, no idling
        no_idle = 1'b1;
        load_settings(32'd2, 32'd3, 32'd16000, 32'hFFFF_0000, 32'd131072, 32'd6554);
        queue_trace(200, 0, 0, 1'b0);
        drain();
        no_idle = 1'b0;

        while (queued_items < 1500) begin
            write_reg(REG_RISE, pick_len());
            write_reg(REG_GAP, pick_len());
            case ($urandom_range(0, 3))
                0: word = 32'd0;
                1: word = 32'h000F_FFFF;
                2: word = $urandom();
                default: word = ($urandom_range(0, 65535) << 4) | $urandom_range(0, 15);
            endcase
            write_reg(REG_BASE, word);
            write_reg(REG_COEF_T, pick_coef());
            write_reg(REG_COEF_L, pick_coef());
            case ($urandom_range(0, 4))
                0: word = 32'd0;
                1: word = 32'd65536;
                2: word = 32'h0001_FFFF | ($urandom() & 32'hFFFE_0000);
                3: word = $urandom();
                default: word = $urandom_range(1000, 8000);
            endcase
            write_reg(REG_NORM, word);
            @(posedge i_clk);
            repeat ($urandom_range(3, 8)) begin
                if ($urandom_range(0, 4) == 0) len = $urandom_range(1, window_need());
                else len = window_need() + $urandom_range(0, 20);
                queue_trace(len, $urandom_range(0, 3), int'(cfg_base >> 4),
                            $urandom_range(0, 3) == 0);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: trapezoidal_energy_filter.f
rtl/tef_pkg.sv
rtl/tef_regs.sv
rtl/tef_ctrl.sv
rtl/tef_datapath.sv
rtl/trapezoidal_energy_filter.sv
rtl/tef_checker.sv
tb/tb_top.sv
